### rtl/gdm_pkg.sv
// gdm_pkg: types, codes and widths shared by the gradient direction map
// controller, datapath and top level. No dependencies.
package gdm_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] REG_WIDTH     = 3'd0;
  localparam logic [2:0] REG_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_OPERATOR  = 3'd2;
  localparam logic [2:0] REG_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_SUM_MODE  = 3'd4;

  // operator codes
  localparam logic [1:0] OP_PREWITT = 2'd0;
  localparam logic [1:0] OP_SOBEL   = 2'd1;
  localparam logic [1:0] OP_SCHARR  = 2'd2;
  localparam logic [1:0] OP_LSD     = 2'd3;

  // edge direction codes
  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_HORIZ = 2'd1;
  localparam logic [1:0] DIR_VERT  = 2'd2;

  // field and working widths
  localparam int CFG_W   = 13;
  localparam int ROW_W   = 12;
  localparam int COL_W   = 11;
  localparam int MAG_W   = 13;
  localparam int WV_W    = 14;  // clamped width, up to 8192
  localparam int HV_W    = 15;  // clamped height, up to 16384
  localparam int G_W     = 12;  // |gx|, |gy| at most 4080
  localparam int GS_W    = 14;  // signed gradient sums
  localparam int SQ_W    = 24;
  localparam int RAD_W   = 25;  // gx^2+gy^2 below 2^25
  localparam int RES_W   = 26;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_GRAD,
    ST_SQUARE,
    ST_RINIT,
    ST_ROOT,
    ST_EVAL_EMIT
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic win_load;
    logic grad_en;
    logic sq_en;
    logic root_init;
    logic root_step;
    logic eval_en;
    logic take;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic root_done;
    logic pend_any;
    logic sum_mode;
  } stat_t;

endpackage

### rtl/gdm_ctrl.sv
// gdm_ctrl: sequencer for one pixel at a time: read, window shift,
// gradient, optional square root, then hand out the pending results.
// Depends on gdm_pkg.
module gdm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  gdm_pkg::stat_t  stat,
  output gdm_pkg::cmd_t   cmd
);

  gdm_pkg::state_t state;
  gdm_pkg::state_t state_next;
  logic eval_done;
  logic eval_done_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gdm_pkg::ST_CLEAR;
      eval_done <= 1'b0;
    end else begin
      state     <= state_next;
      eval_done <= eval_done_next;
    end
  end

  // next state
  always_comb begin
    state_next     = state;
    eval_done_next = eval_done;
    case (state)
      gdm_pkg::ST_CLEAR: begin
        if (stat.clear_done) state_next = gdm_pkg::ST_IDLE;
      end
      gdm_pkg::ST_IDLE: begin
        if (in_valid) state_next = gdm_pkg::ST_READ;
      end
      gdm_pkg::ST_READ: state_next = gdm_pkg::ST_GRAD;
      gdm_pkg::ST_GRAD: begin
        eval_done_next = 1'b0;
        state_next = stat.sum_mode ? gdm_pkg::ST_EVAL_EMIT : gdm_pkg::ST_SQUARE;
      end
      gdm_pkg::ST_SQUARE: state_next = gdm_pkg::ST_RINIT;
      gdm_pkg::ST_RINIT: state_next = gdm_pkg::ST_ROOT;
      gdm_pkg::ST_ROOT: begin
        eval_done_next = 1'b0;
        if (stat.root_done) state_next = gdm_pkg::ST_EVAL_EMIT;
      end
      gdm_pkg::ST_EVAL_EMIT: begin
        eval_done_next = 1'b1;
        if (eval_done && !stat.pend_any) state_next = gdm_pkg::ST_IDLE;
      end
      default: state_next = gdm_pkg::ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      gdm_pkg::ST_CLEAR: cmd.clear_en = 1'b1;
      gdm_pkg::ST_IDLE:  in_ready = 1'b1;
      gdm_pkg::ST_READ:  cmd.win_load = 1'b1;
      gdm_pkg::ST_GRAD:  cmd.grad_en = 1'b1;
      gdm_pkg::ST_SQUARE: cmd.sq_en = 1'b1;
      gdm_pkg::ST_RINIT: cmd.root_init = 1'b1;
      gdm_pkg::ST_ROOT:  cmd.root_step = !stat.root_done;
      gdm_pkg::ST_EVAL_EMIT: begin
        if (!eval_done) begin
          cmd.eval_en = 1'b1;
        end else begin
          out_valid  = stat.pend_any;
          cmd.take   = stat.pend_any && out_ready;
          cmd.finish = !stat.pend_any;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/gdm_datapath.sv
// gdm_datapath: configuration registers, line stores, 3x3 window, position
// counters, gradient arithmetic, bit-pair square root and result slots.
// Depends on gdm_pkg.
module gdm_datapath #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr,
  input  logic [2:0]                    cfg_index,
  input  logic [gdm_pkg::CFG_W-1:0]     cfg_data,
  input  logic [7:0]                    pixel,
  input  logic                          in_take,
  input  gdm_pkg::cmd_t                 cmd,
  output gdm_pkg::stat_t                stat,
  output logic [gdm_pkg::ROW_W-1:0]     out_row,
  output logic [gdm_pkg::COL_W-1:0]     out_col,
  output logic [gdm_pkg::MAG_W-1:0]     magnitude,
  output logic [1:0]                    edge_dir,
  output logic                          frame_last
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // configuration registers
  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [1:0]  operator_kind;
  logic [12:0] grad_threshold;
  logic        sum_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 12'd640;
      image_height   <= 13'd480;
      operator_kind  <= gdm_pkg::OP_SOBEL;
      grad_threshold <= 13'd20;
      sum_mode       <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_index)
        gdm_pkg::REG_WIDTH:     image_width    <= cfg_data[11:0];
        gdm_pkg::REG_HEIGHT:    image_height   <= cfg_data[12:0];
        gdm_pkg::REG_OPERATOR:  operator_kind  <= cfg_data[1:0];
        gdm_pkg::REG_THRESHOLD: grad_threshold <= cfg_data[12:0];
        gdm_pkg::REG_SUM_MODE:  sum_mode       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamped frame geometry and threshold
  logic [gdm_pkg::WV_W-1:0] wv;
  logic [gdm_pkg::HV_W-1:0] hv;
  logic [12:0] thr_m1;
  always_comb begin
    if (image_width < 12'd3)
      wv = gdm_pkg::WV_W'(3);
    else if ({2'b0, image_width} > gdm_pkg::WV_W'(MAX_WIDTH))
      wv = gdm_pkg::WV_W'(MAX_WIDTH);
    else
      wv = {2'b0, image_width};
    if (image_height < 13'd3)
      hv = gdm_pkg::HV_W'(3);
    else if ({2'b0, image_height} > gdm_pkg::HV_W'(MAX_HEIGHT))
      hv = gdm_pkg::HV_W'(MAX_HEIGHT);
    else
      hv = {2'b0, image_height};
    thr_m1 = (grad_threshold == 13'd0) ? 13'd0 : grad_threshold - 13'd1;
  end

  // position counters
  logic [gdm_pkg::ROW_W-1:0] row_count;
  logic [gdm_pkg::COL_W-1:0] col_count;
  logic lastcol, lastrow;
  assign lastcol = {3'b0, col_count} >= wv - gdm_pkg::WV_W'(1);
  assign lastrow = {3'b0, row_count} >= hv - gdm_pkg::HV_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (cmd.finish) begin
      if (lastcol) begin
        col_count <= '0;
        row_count <= lastrow ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  // line store address, clamped to the store depth
  logic [AW-1:0] idx;
  assign idx = ({3'b0, col_count} < gdm_pkg::WV_W'(MAX_WIDTH)) ?
               AW'(col_count) : AW'(MAX_WIDTH - 1);

  // clearing pass over the line stores after reset
  logic [AW:0] clr;
  always_ff @(posedge clk) begin
    if (rst) clr <= '0;
    else if (cmd.clear_en && !stat.clear_done) clr <= clr + 1'b1;
  end
  assign stat.clear_done = (clr == (AW+1)'(MAX_WIDTH - 1));

  // line stores, read every cycle at the current column
  logic [7:0] upper_mem [MAX_WIDTH];
  logic [7:0] lower_mem [MAX_WIDTH];
  logic [7:0] upper_rd, lower_rd;
  logic [7:0] px;

  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      upper_mem[clr[AW-1:0]] <= 8'd0;
      lower_mem[clr[AW-1:0]] <= 8'd0;
    end else if (cmd.win_load) begin
      upper_mem[idx] <= lower_rd;
      lower_mem[idx] <= px;
    end
    upper_rd <= upper_mem[idx];
    lower_rd <= lower_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (in_take) px <= pixel;
  end

  // 3x3 window, newest column on the right
  logic [7:0] win [3][3];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] <= 8'd0;
    end else if (cmd.win_load) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= upper_rd;
      win[1][2] <= lower_rd;
      win[2][2] <= px;
    end
  end

  // gradient of the window center
  logic signed [gdm_pkg::GS_W-1:0] pa, pb, pc, pd, px_c, pe, pf, pg, ph;
  logic signed [gdm_pkg::GS_W-1:0] sp, sq, sgx, sgy;
  logic [gdm_pkg::G_W-1:0] gx, gy;

  always_comb begin
    pa   = gdm_pkg::GS_W'(win[0][0]);
    pb   = gdm_pkg::GS_W'(win[0][1]);
    pc   = gdm_pkg::GS_W'(win[0][2]);
    pd   = gdm_pkg::GS_W'(win[1][0]);
    px_c = gdm_pkg::GS_W'(win[1][1]);
    pe   = gdm_pkg::GS_W'(win[1][2]);
    pf   = gdm_pkg::GS_W'(win[2][0]);
    pg   = gdm_pkg::GS_W'(win[2][1]);
    ph   = gdm_pkg::GS_W'(win[2][2]);
    sp   = ph - pa;
    sq   = pc - pf;
    case (operator_kind)
      gdm_pkg::OP_PREWITT: begin
        sgx = sp + sq + (pe - pd);
        sgy = sp - sq + (pg - pb);
      end
      gdm_pkg::OP_SOBEL: begin
        sgx = sp + sq + ((pe - pd) <<< 1);
        sgy = sp - sq + ((pg - pb) <<< 1);
      end
      gdm_pkg::OP_SCHARR: begin
        sgx = (sp + sq) * gdm_pkg::GS_W'(3) + (pe - pd) * gdm_pkg::GS_W'(10);
        sgy = (sp - sq) * gdm_pkg::GS_W'(3) + (pg - pb) * gdm_pkg::GS_W'(10);
      end
      default: begin
        sgx = (ph - px_c) + (pe - pg);
        sgy = (ph - px_c) - (pe - pg);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.grad_en) begin
      gx <= gdm_pkg::G_W'(sgx < 0 ? -sgx : sgx);
      gy <= gdm_pkg::G_W'(sgy < 0 ? -sgy : sgy);
    end
  end

  // squares, one multiplier per axis
  logic [gdm_pkg::SQ_W-1:0] sqx, sqy;
  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      sqx <= gx * gx;
      sqy <= gy * gy;
    end
  end

  // integer square root, one bit pair per cycle
  logic [gdm_pkg::RAD_W-1:0] rad;
  logic [gdm_pkg::RES_W-1:0] root;
  logic [gdm_pkg::RAD_W-1:0] rbit;
  logic [gdm_pkg::RES_W-1:0] trial;
  assign trial = root + gdm_pkg::RES_W'(rbit);

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rad  <= gdm_pkg::RAD_W'(sqx) + gdm_pkg::RAD_W'(sqy);
      root <= '0;
      rbit <= gdm_pkg::RAD_W'(1) << 24;
    end else if (cmd.root_step) begin
      if (gdm_pkg::RES_W'(rad) >= trial) begin
        rad  <= rad - gdm_pkg::RAD_W'(trial);
        root <= (root >> 1) + gdm_pkg::RES_W'(rbit);
      end else begin
        root <= root >> 1;
      end
      rbit <= rbit >> 2;
    end
  end
  assign stat.root_done = (rbit == '0);
  assign stat.sum_mode  = sum_mode;

  // result slots: 0 (r-1,c-1), 1 (r-1,c), 2 (r,c-1), 3 (r,c)
  logic [3:0] pend;
  logic [gdm_pkg::MAG_W-1:0] mag0;
  logic [1:0] dir0;
  logic [gdm_pkg::MAG_W-1:0] s_mag;
  logic [gdm_pkg::MAG_W-1:0] thr_eff;
  logic [gdm_pkg::ROW_W-1:0] ri;
  logic [gdm_pkg::COL_W-1:0] ci;
  logic border;

  assign ri = row_count - 1'b1;
  assign ci = col_count - 1'b1;
  assign thr_eff = thr_m1 + 13'd1;
  assign s_mag = sum_mode ? (gdm_pkg::MAG_W'(gx) + gdm_pkg::MAG_W'(gy))
                          : gdm_pkg::MAG_W'(root);
  assign border = (ri == '0) || ({3'b0, ri} >= hv - gdm_pkg::HV_W'(1)) ||
                  (ci == '0) || ({3'b0, ci} >= wv - gdm_pkg::WV_W'(1));

  // lowest pending slot
  logic [3:0] low_bit;
  assign low_bit = pend & (~pend + 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (cmd.eval_en) begin
      pend[0] <= (row_count != '0) && (col_count != '0);
      pend[1] <= (row_count != '0) && lastcol;
      pend[2] <= lastrow && (col_count != '0);
      pend[3] <= lastrow && lastcol;
    end else if (cmd.take) begin
      pend <= pend & ~low_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_en) begin
      if (border) begin
        mag0 <= thr_m1;
        dir0 <= gdm_pkg::DIR_NONE;
      end else begin
        mag0 <= s_mag;
        if (s_mag >= thr_eff)
          dir0 <= (gx >= gy) ? gdm_pkg::DIR_VERT : gdm_pkg::DIR_HORIZ;
        else
          dir0 <= gdm_pkg::DIR_NONE;
      end
    end
  end
  assign stat.pend_any = (pend != '0);

  // output fields of the lowest pending slot
  always_comb begin
    out_row    = row_count;
    out_col    = col_count;
    magnitude  = thr_m1;
    edge_dir   = gdm_pkg::DIR_NONE;
    frame_last = 1'b0;
    if (pend[0]) begin
      out_row   = ri;
      out_col   = ci;
      magnitude = mag0;
      edge_dir  = dir0;
    end else if (pend[1]) begin
      out_row = ri;
    end else if (pend[2]) begin
      out_col = ci;
    end else begin
      frame_last = 1'b1;
    end
  end

endmodule

### rtl/gradient_direction_map.sv
// gradient_direction_map: top level joining gdm_ctrl and gdm_datapath.
// Depends on gdm_pkg, gdm_ctrl and gdm_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------
//   cfg     | cfg_wr               | cfg_index, cfg_data
//   in      | in_valid / in_ready  | pixel
//   out     | out_valid / out_ready| out_row, out_col, magnitude, edge_dir,
//           |                      | frame_last
//
// one pixel at a time: read, window shift, gradient and evaluation with
// sum_mode, plus squares and the 13-step bit-pair square root without it,
// then the result transfers and a closing step for the pixel.
// after reset a clearing pass zeroes the line stores before the first pixel
// transfer; configuration writes are taken meanwhile.
// a stalled output holds the block; no new pixel is taken until all results
// of the current one have been transferred.
module gradient_direction_map #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr,
  input  logic [2:0]                    cfg_index,
  input  logic [gdm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gdm_pkg::ROW_W-1:0]     out_row,
  output logic [gdm_pkg::COL_W-1:0]     out_col,
  output logic [gdm_pkg::MAG_W-1:0]     magnitude,
  output logic [1:0]                    edge_dir,
  output logic                          frame_last
);

  gdm_pkg::cmd_t  cmd;
  gdm_pkg::stat_t stat;

  // sequencer
  gdm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and arithmetic
  gdm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel      (pixel),
    .in_take    (in_valid && in_ready),
    .cmd        (cmd),
    .stat       (stat),
    .out_row    (out_row),
    .out_col    (out_col),
    .magnitude  (magnitude),
    .edge_dir   (edge_dir),
    .frame_last (frame_last)
  );

endmodule

### dv/gdm_checker.sv
// gdm_checker: watches the config, pixel and result channels of the gradient
// direction map, predicts every result and compares. Depends on gdm_pkg.
module gdm_checker #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr,
  input  logic [2:0]                cfg_index,
  input  logic [gdm_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [7:0]                pixel,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [gdm_pkg::ROW_W-1:0] out_row,
  input  logic [gdm_pkg::COL_W-1:0] out_col,
  input  logic [gdm_pkg::MAG_W-1:0] magnitude,
  input  logic [1:0]                edge_dir,
  input  logic                      frame_last,
  output int                        errors,
  output int                        pending
);

  typedef struct packed {
    logic [gdm_pkg::ROW_W-1:0] row;
    logic [gdm_pkg::COL_W-1:0] col;
    logic [gdm_pkg::MAG_W-1:0] mag;
    logic [1:0]                dir;
    logic                      last;
  } grad_result_t;

  grad_result_t result_fifo[$];

  // shadow of the block's registers and pixel state
  logic [11:0] width_reg;
  logic [12:0] height_reg;
  logic [1:0]  op_reg;
  logic [12:0] thresh_reg;
  logic        sum_reg;
  logic [7:0]  row_above2 [MAX_WIDTH];
  logic [7:0]  row_above1 [MAX_WIDTH];
  logic [7:0]  win [3][3];
  int          row_pos;
  int          col_pos;

  assign pending = result_fifo.size();

  function automatic int floor_sqrt(input int v);
    int r;
    r = 0;
    for (int b = 13; b >= 0; b--) begin
      if ((r | (1 << b)) * (r | (1 << b)) <= v) r = r | (1 << b);
    end
    return r;
  endfunction

  function automatic int iabs(input int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic reset_model();
    width_reg  = 12'd640;
    height_reg = 13'd480;
    op_reg     = gdm_pkg::OP_SOBEL;
    thresh_reg = 13'd20;
    sum_reg    = 1'b1;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_above2[i] = '0;
      row_above1[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    row_pos = 0;
    col_pos = 0;
    result_fifo.delete();
  endtask

  // gradient of the window center
  task automatic center_gradient(input int thr, output int mag, output logic [1:0] dir);
    int a, b, c, d, x, e, f, g, h, p, q, gx, gy;
    a = win[0][0]; b = win[0][1]; c = win[0][2];
    d = win[1][0]; x = win[1][1]; e = win[1][2];
    f = win[2][0]; g = win[2][1]; h = win[2][2];
    p = h - a;
    q = c - f;
    case (op_reg)
      gdm_pkg::OP_PREWITT: begin
        gx = iabs(p + q + (e - d));
        gy = iabs(p - q + (g - b));
      end
      gdm_pkg::OP_SOBEL: begin
        gx = iabs(p + q + 2 * (e - d));
        gy = iabs(p - q + 2 * (g - b));
      end
      gdm_pkg::OP_SCHARR: begin
        gx = iabs(3 * (p + q) + 10 * (e - d));
        gy = iabs(3 * (p - q) + 10 * (g - b));
      end
      default: begin
        gx = iabs((h - x) + (e - g));
        gy = iabs((h - x) - (e - g));
      end
    endcase
    mag = sum_reg ? gx + gy : floor_sqrt(gx * gx + gy * gy);
    if (mag >= thr) dir = (gx >= gy) ? gdm_pkg::DIR_VERT : gdm_pkg::DIR_HORIZ;
    else dir = gdm_pkg::DIR_NONE;
  endtask

  task automatic queue_result(input int r, input int c, input int mag,
                              input logic [1:0] dir, input logic last);
    grad_result_t res;
    res.row  = r[gdm_pkg::ROW_W-1:0];
    res.col  = c[gdm_pkg::COL_W-1:0];
    res.mag  = mag[gdm_pkg::MAG_W-1:0];
    res.dir  = dir;
    res.last = last;
    result_fifo.insert(result_fifo.size(), res);
  endtask

  // one pixel transfer: shift the window, update line stores, queue results
  task automatic predict_pixel(input logic [7:0] px);
    int w, hgt, thr, r, c, idx, mag;
    logic [1:0] dir;
    bit lastcol, lastrow;
    w   = width_reg;
    hgt = height_reg;
    thr = (thresh_reg < 1) ? 1 : thresh_reg;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (hgt < 3) hgt = 3;
    if (hgt > MAX_HEIGHT) hgt = MAX_HEIGHT;
    r = row_pos;
    c = col_pos;
    lastcol = c >= w - 1;
    lastrow = r >= hgt - 1;
    idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = row_above2[idx];
    win[1][2] = row_above1[idx];
    win[2][2] = px;
    row_above2[idx] = row_above1[idx];
    row_above1[idx] = px;
    if (r >= 1 && c >= 1) begin
      if (r - 1 == 0 || r - 1 >= hgt - 1 || c - 1 == 0 || c - 1 >= w - 1) begin
        mag = thr - 1;
        dir = gdm_pkg::DIR_NONE;
      end else begin
        center_gradient(thr, mag, dir);
      end
      queue_result(r - 1, c - 1, mag, dir, 1'b0);
    end
    if (r >= 1 && lastcol) queue_result(r - 1, c, thr - 1, gdm_pkg::DIR_NONE, 1'b0);
    if (lastrow && c >= 1) queue_result(r, c - 1, thr - 1, gdm_pkg::DIR_NONE, 1'b0);
    if (lastrow && lastcol) queue_result(r, c, thr - 1, gdm_pkg::DIR_NONE, 1'b1);
    if (lastcol) begin
      col_pos = 0;
      row_pos = lastrow ? 0 : ((r + 1) & 12'hfff);
    end else begin
      col_pos = (c + 1) & 11'h7ff;
    end
  endtask

  // sample all channels on the rising edge
  always @(posedge clk) begin
    grad_result_t exp_res;
    if (rst) begin
      reset_model();
      errors = 0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          gdm_pkg::REG_WIDTH:     width_reg  = cfg_data[11:0];
          gdm_pkg::REG_HEIGHT:    height_reg = cfg_data[12:0];
          gdm_pkg::REG_OPERATOR:  op_reg     = cfg_data[1:0];
          gdm_pkg::REG_THRESHOLD: thresh_reg = cfg_data[12:0];
          gdm_pkg::REG_SUM_MODE:  sum_reg    = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_pixel(pixel);
      if (out_valid && out_ready) begin
        if (result_fifo.size() == 0) begin
          $error("result transfer with nothing expected: row %0d col %0d", out_row, out_col);
          errors++;
        end else begin
          exp_res = result_fifo.pop_front();
          if (out_row !== exp_res.row) begin
            $error("out_row: expected %0d, actual %0d", exp_res.row, out_row);
            errors++;
          end
          if (out_col !== exp_res.col) begin
            $error("out_col: expected %0d, actual %0d", exp_res.col, out_col);
            errors++;
          end
          if (magnitude !== exp_res.mag) begin
            $error("magnitude: expected %0d, actual %0d", exp_res.mag, magnitude);
            errors++;
          end
          if (edge_dir !== exp_res.dir) begin
            $error("edge_dir: expected %0d, actual %0d", exp_res.dir, edge_dir);
            errors++;
          end
          if (frame_last !== exp_res.last) begin
            $error("frame_last: expected %0d, actual %0d", exp_res.last, frame_last);
            errors++;
          end
        end
      end
    end
  end

endmodule

### dv/gradient_direction_map_tb.sv
// gradient_direction_map_tb: drives pixel frames and register settings into
// the gradient direction map and gives the verdict. Depends on gdm_pkg, gdm_checker.
module gradient_direction_map_tb;

  localparam int STALL_LIMIT = 8000;
  localparam int DRAIN_WAIT  = 60;
  localparam int HOLD_CYCLES = 400;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wr = 1'b0;
  logic [2:0]                cfg_index = gdm_pkg::REG_WIDTH;
  logic [gdm_pkg::CFG_W-1:0] cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                pixel = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [gdm_pkg::ROW_W-1:0] out_row;
  logic [gdm_pkg::COL_W-1:0] out_col;
  logic [gdm_pkg::MAG_W-1:0] magnitude;
  logic [1:0]                edge_dir;
  logic                      frame_last;
  int                        errors;
  int                        pending;
  bit                        no_idle = 1'b0;
  bit                        hold_req = 1'b0;
  bit                        hold_done = 1'b0;
  int                        hold_cnt = 0;
  int                        quiet_cycles = 0;

  gradient_direction_map uut (
    .clk(clk), .rst(rst), .cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
    .out_valid(out_valid), .out_ready(out_ready), .out_row(out_row), .out_col(out_col),
    .magnitude(magnitude), .edge_dir(edge_dir), .frame_last(frame_last)
  );

  gdm_checker u_checker (
    .clk(clk), .rst(rst), .cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
    .out_valid(out_valid), .out_ready(out_ready), .out_row(out_row), .out_col(out_col),
    .magnitude(magnitude), .edge_dir(edge_dir), .frame_last(frame_last),
    .errors(errors), .pending(pending)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // result side: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= 9);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // write all five registers back to back, called at a falling edge
  task automatic write_regs(input int w, input int h, input int op, input int thr,
                            input int sum);
    int vals[5];
    vals = '{w, h, op, thr, sum};
    for (int i = 0; i < 5; i++) begin
      cfg_wr <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i][gdm_pkg::CFG_W-1:0];
      @(negedge clk);
    end
    cfg_wr <= 1'b0;
    @(negedge clk);
  endtask

  // one pixel transfer, entered and left at a falling edge
  task automatic send_pixel(input logic [7:0] px);
    while (!no_idle && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_pixel();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int w, h, op, thr, sum, count;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: full 5x4 Scharr frame of alternating extremes
    write_regs(5, 4, gdm_pkg::OP_SCHARR, 20, 1);
    for (int i = 0; i < 20; i++) send_pixel(((i + i / 5) % 2) ? 8'hff : 8'h00);
    in_valid <= 1'b0;
    wait_drained();

    // phases of settings, extremes first, then random
    for (int ph = 0; ph < 13; ph++) begin
      w   = $urandom_range(3, 9);
      h   = $urandom_range(3, 6);
      op  = ph % 4;
      sum = (ph / 4) % 2;
      thr = $urandom_range(1, 120);
      count = $urandom_range(8, 14);
      case (ph)
        0: begin w = 0; h = 0; thr = 0; end
        1: begin w = 1; h = 2; thr = 8191; end
        2: begin w = 4095; h = 3; end
        3: begin w = 2048; h = 8191; thr = 1; count = 12; end
        5: no_idle = 1'b1;
        7: hold_req = 1'b1;
        default: ;
      endcase
      write_regs(w, h, op, thr, sum);
      for (int i = 0; i < count; i++) begin
        send_pixel(rand_pixel());
        if (ph == 9 && i == 6) begin
          in_valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
      in_valid <= 1'b0;
      no_idle = 1'b0;
      wait_drained();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/gdm_pkg.sv
rtl/gdm_ctrl.sv
rtl/gdm_datapath.sv
rtl/gradient_direction_map.sv
dv/gdm_checker.sv
dv/gradient_direction_map_tb.sv
